FILE: rtl/dlbd_pkg.sv
// Package for the definite-length block deframer.
// Holds field widths, register indexes, the parse phase type and the digit decoders.
// No dependencies.
package dlbd_pkg;

   localparam int BYTE_W     = 8;
   localparam int RL_W       = 30;
   localparam int BPP_W      = 2;
   localparam int FC_W       = 17;
   localparam int RL_BPP_W   = RL_W + BPP_W;
   localparam int PROD_W     = RL_BPP_W + FC_W;
   localparam int CSR_DATA_W = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int NDIG_W     = 4;

   localparam logic [BYTE_W-1:0] HASH_CHAR = 8'h23;

   localparam logic [CSR_IDX_W-1:0] CSR_ARMED         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUMMARY_FRAME = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_FRAME    = 3'd5;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_COUNT   = 2'd1,
      PH_DIGITS  = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef struct packed {
      logic                 valid;
      logic [NDIG_W-1:0]    value;
   } digit_type;

   // Hex count digit: '0'-'9', 'a'-'f', 'A'-'F'.
   function automatic digit_type hex_digit(input logic [BYTE_W-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = NDIG_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = NDIG_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = NDIG_W'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   // Decimal length digit: '0'-'9'.
   function automatic digit_type dec_digit(input logic [BYTE_W-1:0] c);
      digit_type d;
      d.valid = (c >= 8'h30 && c <= 8'h39);
      d.value = NDIG_W'(c - 8'h30);
      return d;
   endfunction

endpackage

FILE: rtl/dlbd_req_if.sv
// Input channel of the deframer: one received byte per transfer.
// Depends on dlbd_pkg.
interface dlbd_req_if;
   logic                        valid;
   logic                        ready;
   logic [dlbd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/dlbd_rsp_if.sv
// Result channel of the deframer: one payload byte per transfer, last one marked.
// Depends on dlbd_pkg.
interface dlbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dlbd_pkg::BYTE_W-1:0] payload_byte;
   logic                        final_byte;

   modport source (output valid, output payload_byte, output final_byte, input ready);
   modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

FILE: rtl/definite_length_block_deframer_unit.sv
// Definite-length block deframer: parses '#', count digit, length digits, payload.
// A payload byte is registered and appears on the result channel in the cycle after its transfer.
// Throughput: one byte per cycle; the input stalls only when the result register is
// full and not taken, during a register write, and while cfg_pend_ff is set (after reset
// and after a write) as the registered expected-length product (one 32x17 multiply) settles.
// Reset: synchronous, active high; configuration registers take their defaults, parser hunts for '#'.
module definite_length_block_deframer_unit #(
   parameter int MAX_LEN_DIGITS = 15,
   parameter int LEN_BITS       = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   dlbd_req_if.sink                          req_if,
   dlbd_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [dlbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dlbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dlbd_pkg::*;

   localparam int ACC_W = LEN_BITS + 4;
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   // configuration registers
   logic             armed_ff;
   logic [RL_W-1:0]  record_length_ff;
   logic [BPP_W-1:0] bytes_per_point_ff;
   logic [FC_W-1:0]  frame_count_ff;
   logic             summary_frame_ff;
   logic             fast_frame_ff;
   logic             cfg_pend_ff;

   // expected length, registered from the configuration
   logic [RL_BPP_W-1:0] rl_bpp;
   logic [FC_W-1:0]     frames;
   logic [PROD_W-1:0]   product;
   logic [LEN_BITS-1:0] want_ff;
   logic                want_ok_ff;

   // parse state
   phase_type           phase_ff, phase_in;
   logic [NDIG_W-1:0]   digits_left_ff, digits_left_in;
   logic [LEN_BITS-1:0] length_accum_ff, length_accum_in;
   logic                length_overflow_ff, length_overflow_in;
   logic [LEN_BITS-1:0] payload_left_ff, payload_left_in;

   // result register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] payload_byte_ff;
   logic              final_byte_ff;

   logic              req_ready;
   logic              take;
   logic              emit;
   logic              last;
   digit_type         hd;
   digit_type         dd;
   logic [ACC_W-1:0]  acc_wide;
   logic [LEN_BITS-1:0] acc_sat;
   logic              acc_ovf;
   logic [NDIG_W-1:0] dl_dec;

   assign req_ready    = !csr_we && !cfg_pend_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = req_ready;
   assign take         = req_if.valid && req_ready;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff           <= 1'b0;
         record_length_ff   <= RL_W'(1);
         bytes_per_point_ff <= BPP_W'(1);
         frame_count_ff     <= FC_W'(1);
         summary_frame_ff   <= 1'b0;
         fast_frame_ff      <= 1'b0;
         cfg_pend_ff        <= 1'b1;
      end else begin
         cfg_pend_ff <= csr_we;
         if (csr_we) begin
            case (csr_index)
               CSR_ARMED:         armed_ff           <= csr_wdata[0];
               CSR_RECORD_LENGTH: record_length_ff   <= csr_wdata[RL_W-1:0];
               CSR_BYTES_PER_PT:  bytes_per_point_ff <= csr_wdata[BPP_W-1:0];
               CSR_FRAME_COUNT:   frame_count_ff     <= csr_wdata[FC_W-1:0];
               CSR_SUMMARY_FRAME: summary_frame_ff   <= csr_wdata[0];
               CSR_FAST_FRAME:    fast_frame_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign rl_bpp = ({{BPP_W{1'b0}}, record_length_ff} & {RL_BPP_W{bytes_per_point_ff[0]}})
                 + ({1'b0, record_length_ff, 1'b0} & {RL_BPP_W{bytes_per_point_ff[1]}});
   assign frames  = (fast_frame_ff && !summary_frame_ff) ? frame_count_ff : FC_W'(1);
   assign product = PROD_W'(rl_bpp) * PROD_W'(frames);

   always_ff @(posedge clock) begin
      want_ff    <= product[LEN_BITS-1:0];
      want_ok_ff <= (product != '0) && (product[PROD_W-1:LEN_BITS] == '0);
   end

   // ---------------- parse: next state ----------------
   assign hd       = hex_digit(req_if.rx_byte);
   assign dd       = dec_digit(req_if.rx_byte);
   assign acc_wide = ({4'b0, length_accum_ff} << 3) + ({4'b0, length_accum_ff} << 1)
                   + ACC_W'(dd.value);
   assign acc_ovf  = (acc_wide[ACC_W-1:LEN_BITS] != '0);
   assign acc_sat  = acc_ovf ? LEN_MAX : acc_wide[LEN_BITS-1:0];
   assign dl_dec   = digits_left_ff - NDIG_W'(1);
   assign last     = (payload_left_ff <= LEN_BITS'(1));

   always_comb begin
      phase_in           = phase_ff;
      digits_left_in     = digits_left_ff;
      length_accum_in    = length_accum_ff;
      length_overflow_in = length_overflow_ff;
      payload_left_in    = payload_left_ff;
      if (take && armed_ff) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_if.rx_byte == HASH_CHAR) phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               if (!hd.valid || hd.value == '0 || hd.value > NDIG_W'(MAX_LEN_DIGITS)) begin
                  phase_in = PH_HUNT;
                  digits_left_in = '0;
                  length_accum_in = '0;
                  length_overflow_in = 1'b0;
                  payload_left_in = '0;
               end else begin
                  phase_in = PH_DIGITS;
                  digits_left_in = hd.value;
                  length_accum_in = '0;
                  length_overflow_in = 1'b0;
               end
            end
            PH_DIGITS: begin
               // drop on a bad digit, or on a completed length that does not match
               if (!dd.valid || (dl_dec == '0 && ((length_overflow_ff || acc_ovf)
                      || !want_ok_ff || acc_sat != want_ff))) begin
                  phase_in = PH_HUNT;
                  digits_left_in = '0;
                  length_accum_in = '0;
                  length_overflow_in = 1'b0;
                  payload_left_in = '0;
               end else begin
                  digits_left_in = dl_dec;
                  length_accum_in = acc_sat;
                  length_overflow_in = length_overflow_ff || acc_ovf;
                  if (dl_dec == '0) begin
                     phase_in = PH_PAYLOAD;
                     payload_left_in = acc_sat;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (last) begin
                  phase_in = PH_HUNT;
                  digits_left_in = '0;
                  length_accum_in = '0;
                  length_overflow_in = 1'b0;
                  payload_left_in = '0;
               end else begin
                  payload_left_in = payload_left_ff - LEN_BITS'(1);
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // ---------------- parse: outputs ----------------
   always_comb begin
      case (phase_ff)
         PH_PAYLOAD: emit = take && armed_ff;
         default:    emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_we && csr_index == CSR_ARMED)) begin
         phase_ff           <= PH_HUNT;
         digits_left_ff     <= '0;
         length_accum_ff    <= '0;
         length_overflow_ff <= 1'b0;
         payload_left_ff    <= '0;
      end else begin
         phase_ff           <= phase_in;
         digits_left_ff     <= digits_left_in;
         length_accum_ff    <= length_accum_in;
         length_overflow_ff <= length_overflow_in;
         payload_left_ff    <= payload_left_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         payload_byte_ff <= req_if.rx_byte;
         final_byte_ff   <= last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.payload_byte = payload_byte_ff;
   assign rsp_if.final_byte   = final_byte_ff;

endmodule
